// ===== hw/rtl/pbpe_pkg.sv =====
// Shared types, constants and arithmetic helpers for the pixel blend program engine.
// No dependencies; every other file of the block uses this package by scoped names.
`default_nettype none

package pbpe_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int PROG_DEPTH_DEF = 16;
   localparam int REG_COUNT_DEF  = 16;

   // Fixed-point format: sign, 8 integer bits, FRAC_BITS fraction bits.
   localparam int FRAC_BITS = 16;
   localparam int VAL_BITS  = FRAC_BITS + 9;
   localparam int SUM_BITS  = VAL_BITS + 12;

   localparam logic signed [SUM_BITS-1:0] VAL_MAX =
      (SUM_BITS'(1) <<< (VAL_BITS - 1)) - SUM_BITS'(1);
   localparam logic signed [SUM_BITS-1:0] VAL_MIN = -VAL_MAX - SUM_BITS'(1);

   // Request payload layout inside req_tdata.
   localparam int REQ_DATA_BITS = 128;

   // Instruction opcodes.
   localparam logic [3:0] OP_SPLAT = 4'd0;
   localparam logic [3:0] OP_LDSRC = 4'd1;
   localparam logic [3:0] OP_LDDST = 4'd2;
   localparam logic [3:0] OP_LDCOV = 4'd3;
   localparam logic [3:0] OP_STORE = 4'd4;
   localparam logic [3:0] OP_MOV   = 4'd5;
   localparam logic [3:0] OP_ADD   = 4'd6;
   localparam logic [3:0] OP_SUB   = 4'd7;
   localparam logic [3:0] OP_MUL   = 4'd8;
   localparam logic [3:0] OP_MAD   = 4'd9;

   typedef struct packed {
      logic [3:0]                kind;
      logic [3:0]                d;
      logic [3:0]                a;
      logic [3:0]                b;
      logic [3:0]                c;
      logic signed [VAL_BITS-1:0] imm;
   } instr_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_PROG_WR,
      CMD_START,
      CMD_FETCH,
      CMD_DECODE,
      CMD_LOAD,
      CMD_STORE_LO,
      CMD_STORE_HI,
      CMD_MOV_WB,
      CMD_ALU_WB,
      CMD_MUL,
      CMD_RND,
      CMD_MUL_WB,
      CMD_RESULT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [1:0] lane;
   } cmd_type;

   typedef struct packed {
      logic [3:0] kind;
      logic       bad;
   } status_type;

   // round(byte * 2^16 / 255) equals byte * 257 plus one for bytes of 128 and up.
   function automatic logic [VAL_BITS-1:0] load_byte(input logic [7:0] b);
      return VAL_BITS'({b, b}) + VAL_BITS'(b[7]);
   endfunction

   // Clamp to 0..1.0, then scale to a byte with rounding.
   function automatic logic [7:0] store_byte(input logic signed [VAL_BITS-1:0] v);
      logic [FRAC_BITS:0]  c;
      logic [VAL_BITS-1:0] u;
      if (v < 0) begin
         c = '0;
      end else if (v > $signed(VAL_BITS'(1 << FRAC_BITS))) begin
         c = (FRAC_BITS+1)'(1 << FRAC_BITS);
      end else begin
         c = v[FRAC_BITS:0];
      end
      u = (VAL_BITS'(c) << 8) - VAL_BITS'(c) + VAL_BITS'(1 << (FRAC_BITS - 1));
      return u[FRAC_BITS+7:FRAC_BITS];
   endfunction

   function automatic logic signed [VAL_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] r;
      if (v > VAL_MAX) begin
         r = VAL_MAX;
      end else if (v < VAL_MIN) begin
         r = VAL_MIN;
      end else begin
         r = v;
      end
      return r[VAL_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbpe_ctrl.sv =====
// Sequencer for the pixel blend program engine: handshakes, program counter, op steps.
// Depends on pbpe_pkg; drives pbpe_dpath through a command struct.
`default_nettype none

module pbpe_ctrl #(
   parameter int PROG_DEPTH = pbpe_pkg::PROG_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tuser,
   output      logic                              req_tready,
   input  wire logic                              rsp_tready,
   output      logic                              rsp_tvalid,
   input  wire logic                              csr_wr_en,
   input  wire logic [4:0]                        csr_wr_data,
   output      logic [$clog2(PROG_DEPTH+1)-1:0]   pc,
   output      pbpe_pkg::cmd_type                 cmd,
   input  wire pbpe_pkg::status_type              status
);

   localparam int PCW = $clog2(PROG_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_DECODE, ST_LOAD, ST_ST_LO, ST_ST_HI,
      ST_MOV_WB, ST_ALU_WB, ST_MUL, ST_RND, ST_MUL_WB, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [PCW-1:0]   pc_ff, pc_in;
   logic [1:0]       lane_ff, lane_in;
   logic [4:0]       len_ff, len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [8:0]       len_eff;
   logic [8:0]       pc_next_w;
   logic             issue;

   assign len_eff   = (9'(len_ff) < 9'(PROG_DEPTH)) ? 9'(len_ff) : 9'(PROG_DEPTH);
   assign pc_next_w = 9'(pc_ff) + 9'd1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign pc         = pc_ff;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      lane_in      = lane_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      issue        = 1'b0;
      cmd.op       = pbpe_pkg::CMD_NONE;
      cmd.lane     = lane_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  cmd.op   = pbpe_pkg::CMD_START;
                  pc_in    = '0;
                  state_in = (len_eff == 9'd0) ? ST_DONE : ST_FETCH;
               end else begin
                  cmd.op = pbpe_pkg::CMD_PROG_WR;
               end
            end
         end
         ST_FETCH: begin
            cmd.op   = pbpe_pkg::CMD_FETCH;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.op   = pbpe_pkg::CMD_DECODE;
            lane_in  = '0;
            state_in = ST_FETCH;
            if (!status.bad) begin
               unique case (status.kind) inside
                  pbpe_pkg::OP_LDSRC, pbpe_pkg::OP_LDDST: state_in = ST_LOAD;
                  pbpe_pkg::OP_STORE: state_in = ST_ST_LO;
                  pbpe_pkg::OP_MOV:   state_in = ST_MOV_WB;
                  pbpe_pkg::OP_ADD, pbpe_pkg::OP_SUB: state_in = ST_ALU_WB;
                  pbpe_pkg::OP_MUL, pbpe_pkg::OP_MAD: state_in = ST_MUL;
                  default: state_in = ST_FETCH;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.op   = pbpe_pkg::CMD_LOAD;
            lane_in  = lane_ff + 2'd1;
            state_in = (lane_ff == 2'd3) ? ST_FETCH : ST_LOAD;
         end
         ST_ST_LO: begin
            cmd.op   = pbpe_pkg::CMD_STORE_LO;
            state_in = ST_ST_HI;
         end
         ST_ST_HI: begin
            cmd.op   = pbpe_pkg::CMD_STORE_HI;
            state_in = ST_FETCH;
         end
         ST_MOV_WB: begin
            cmd.op   = pbpe_pkg::CMD_MOV_WB;
            state_in = ST_FETCH;
         end
         ST_ALU_WB: begin
            cmd.op   = pbpe_pkg::CMD_ALU_WB;
            state_in = ST_FETCH;
         end
         ST_MUL: begin
            cmd.op   = pbpe_pkg::CMD_MUL;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.op   = pbpe_pkg::CMD_RND;
            state_in = ST_MUL_WB;
         end
         ST_MUL_WB: begin
            cmd.op   = pbpe_pkg::CMD_MUL_WB;
            state_in = ST_FETCH;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = pbpe_pkg::CMD_RESULT;
               issue    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // An instruction ends whenever the next state returns to fetch.
      if (state_ff != ST_IDLE && state_ff != ST_DONE && state_ff != ST_FETCH
          && state_in == ST_FETCH) begin
         pc_in = pc_next_w[PCW-1:0];
         if (pc_next_w == len_eff) begin
            state_in = ST_DONE;
         end
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         lane_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         lane_ff      <= lane_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pbpe_dpath.sv =====
// Datapath of the pixel blend program engine: program store, register file, ALU, result.
// Depends on pbpe_pkg; steered by commands from pbpe_ctrl.
`default_nettype none

module pbpe_dpath #(
   parameter int PROG_DEPTH = pbpe_pkg::PROG_DEPTH_DEF,
   parameter int REG_COUNT  = pbpe_pkg::REG_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [pbpe_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                                req_tlast,
   input  wire logic [$clog2(PROG_DEPTH+1)-1:0]     pc,
   input  wire pbpe_pkg::cmd_type                   cmd,
   output      pbpe_pkg::status_type                status,
   output      logic [31:0]                         rsp_tdata,
   output      logic                                rsp_tuser,
   output      logic                                rsp_tlast
);

   localparam int VB   = pbpe_pkg::VAL_BITS;
   localparam int FB   = pbpe_pkg::FRAC_BITS;
   localparam int SB   = pbpe_pkg::SUM_BITS;
   localparam int PIDX = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
   localparam int RIDX = $clog2(REG_COUNT);
   localparam int PW   = 2 * VB;
   localparam int QW   = PW - FB + 1;

   pbpe_pkg::instr_type    prog_mem [PROG_DEPTH];
   logic signed [VB-1:0]   rf_mem   [REG_COUNT];
   logic [REG_COUNT-1:0]   rf_valid_ff;

   pbpe_pkg::instr_type    ir_ff;
   pbpe_pkg::instr_type    wr_word;
   logic signed [VB-1:0]   ma_ff, mb_ff;
   logic                   va_ff, vb_ff;
   logic signed [VB-1:0]   rd_a, rd_b;
   logic [31:0]            src_ff, pix_ff;
   logic [7:0]             cov_ff;
   logic                   last_ff, fault_ff;
   logic [15:0]            byte01_ff;
   logic [PW-1:0]          prod_ff;
   logic                   neg_ff;
   logic signed [QW:0]     q_ff;
   logic [31:0]            out_rgba_ff;
   logic                   out_fault_ff, out_last_ff;

   logic [3:0]             f_addr;
   logic [8:0]             addr_w;
   logic [4:0]             d3;
   logic                   okd, okd3, oka, okb, okc, bad;
   logic                   rd_en;
   logic [4:0]             ra_idx, rb_idx;
   logic                   wr_en;
   logic [4:0]             wr_idx;
   logic signed [VB-1:0]   wr_data;
   logic [31:0]            ld_px;
   logic [7:0]             ld_byte;
   logic [VB-1:0]          mag_a, mag_b;
   logic [PW:0]            rnd_sum;
   logic signed [SB-1:0]   alu_sum, mad_sum;

   function automatic logic ok(input logic [4:0] x);
      return 8'(x) < 8'(REG_COUNT);
   endfunction

   function automatic logic [RIDX-1:0] radr(input logic [4:0] x);
      logic [7:0] w;
      w = 8'(x);
      return w[RIDX-1:0];
   endfunction

   // Request fields, lowest bits first.
   assign f_addr        = req_tdata[3:0];
   assign wr_word.kind  = req_tdata[7:4];
   assign wr_word.d     = req_tdata[11:8];
   assign wr_word.a     = req_tdata[15:12];
   assign wr_word.b     = req_tdata[19:16];
   assign wr_word.c     = req_tdata[23:20];
   assign wr_word.imm   = req_tdata[48:24];
   assign addr_w        = 9'(f_addr);

   // Index checks on the current instruction.
   assign d3   = 5'(ir_ff.d) + 5'd3;
   assign okd  = ok(5'(ir_ff.d));
   assign okd3 = ok(d3);
   assign oka  = ok(5'(ir_ff.a));
   assign okb  = ok(5'(ir_ff.b));
   assign okc  = ok(5'(ir_ff.c));

   always_comb begin
      unique case (ir_ff.kind) inside
         pbpe_pkg::OP_SPLAT, pbpe_pkg::OP_LDCOV: bad = !okd;
         pbpe_pkg::OP_LDSRC, pbpe_pkg::OP_LDDST, pbpe_pkg::OP_STORE: bad = !(okd && okd3);
         pbpe_pkg::OP_MOV: bad = !(okd && oka);
         pbpe_pkg::OP_ADD, pbpe_pkg::OP_SUB, pbpe_pkg::OP_MUL: bad = !(okd && oka && okb);
         pbpe_pkg::OP_MAD: bad = !(okd && oka && okb && okc);
         default: bad = 1'b0;
      endcase
   end

   assign status.kind = ir_ff.kind;
   assign status.bad  = bad;

   // Register file read ports.
   always_comb begin
      rd_en  = 1'b0;
      ra_idx = 5'(ir_ff.a);
      rb_idx = 5'(ir_ff.b);
      case (cmd.op)
         pbpe_pkg::CMD_DECODE: begin
            rd_en = 1'b1;
            if (ir_ff.kind == pbpe_pkg::OP_STORE) begin
               ra_idx = 5'(ir_ff.d);
               rb_idx = 5'(ir_ff.d) + 5'd1;
            end
         end
         pbpe_pkg::CMD_STORE_LO: begin
            rd_en  = 1'b1;
            ra_idx = 5'(ir_ff.d) + 5'd2;
            rb_idx = d3;
         end
         pbpe_pkg::CMD_MUL: begin
            rd_en  = 1'b1;
            ra_idx = 5'(ir_ff.c);
         end
         default: rd_en = 1'b0;
      endcase
   end

   assign rd_a = va_ff ? ma_ff : '0;
   assign rd_b = vb_ff ? mb_ff : '0;

   // Writeback selection.
   assign ld_px   = (ir_ff.kind == pbpe_pkg::OP_LDSRC) ? src_ff : pix_ff;
   assign ld_byte = ld_px[8*cmd.lane +: 8];
   assign alu_sum = (ir_ff.kind == pbpe_pkg::OP_SUB) ? SB'(rd_a) - SB'(rd_b)
                                                     : SB'(rd_a) + SB'(rd_b);
   assign mad_sum = SB'(q_ff) + ((ir_ff.kind == pbpe_pkg::OP_MAD) ? SB'(rd_a) : '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = 5'(ir_ff.d);
      wr_data = '0;
      case (cmd.op)
         pbpe_pkg::CMD_DECODE: begin
            if (!bad && ir_ff.kind == pbpe_pkg::OP_SPLAT) begin
               wr_en   = 1'b1;
               wr_data = ir_ff.imm;
            end else if (!bad && ir_ff.kind == pbpe_pkg::OP_LDCOV) begin
               wr_en   = 1'b1;
               wr_data = pbpe_pkg::load_byte(cov_ff);
            end
         end
         pbpe_pkg::CMD_LOAD: begin
            wr_en   = 1'b1;
            wr_idx  = 5'(ir_ff.d) + 5'(cmd.lane);
            wr_data = pbpe_pkg::load_byte(ld_byte);
         end
         pbpe_pkg::CMD_MOV_WB: begin
            wr_en   = 1'b1;
            wr_data = rd_a;
         end
         pbpe_pkg::CMD_ALU_WB: begin
            wr_en   = 1'b1;
            wr_data = pbpe_pkg::sat(alu_sum);
         end
         pbpe_pkg::CMD_MUL_WB: begin
            wr_en   = 1'b1;
            wr_data = pbpe_pkg::sat(mad_sum);
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Multiplier operands are magnitudes; the sign is applied after rounding.
   assign mag_a   = rd_a[VB-1] ? VB'(-rd_a) : VB'(rd_a);
   assign mag_b   = rd_b[VB-1] ? VB'(-rd_b) : VB'(rd_b);
   assign rnd_sum = (PW+1)'(prod_ff) + (PW+1)'(1 << (FB - 1));

   // Program store.
   always_ff @(posedge clock) begin
      if (cmd.op == pbpe_pkg::CMD_PROG_WR && addr_w < 9'(PROG_DEPTH)) begin
         prog_mem[addr_w[PIDX-1:0]] <= wr_word;
      end
      if (cmd.op == pbpe_pkg::CMD_FETCH) begin
         ir_ff <= prog_mem[pc[PIDX-1:0]];
      end
   end

   // Register file storage and its registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[radr(wr_idx)] <= wr_data;
      end
      if (rd_en) begin
         ma_ff <= rf_mem[radr(ra_idx)];
         mb_ff <= rf_mem[radr(rb_idx)];
      end
   end

   // Entry valid bits; an entry not written in this pixel reads as zero.
   always_ff @(posedge clock) begin
      if (reset || cmd.op == pbpe_pkg::CMD_START) begin
         rf_valid_ff <= '0;
         va_ff       <= 1'b0;
         vb_ff       <= 1'b0;
      end else begin
         if (wr_en) begin
            rf_valid_ff[radr(wr_idx)] <= 1'b1;
         end
         if (rd_en) begin
            va_ff <= rf_valid_ff[radr(ra_idx)];
            vb_ff <= rf_valid_ff[radr(rb_idx)];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= 1'b0;
      end else if (cmd.op == pbpe_pkg::CMD_START) begin
         fault_ff <= 1'b0;
      end else if (cmd.op == pbpe_pkg::CMD_DECODE && bad) begin
         fault_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         pbpe_pkg::CMD_START: begin
            src_ff  <= req_tdata[80:49];
            pix_ff  <= req_tdata[112:81];
            cov_ff  <= req_tdata[120:113];
            last_ff <= req_tlast;
         end
         pbpe_pkg::CMD_STORE_LO: begin
            byte01_ff <= {pbpe_pkg::store_byte(rd_b), pbpe_pkg::store_byte(rd_a)};
         end
         pbpe_pkg::CMD_STORE_HI: begin
            pix_ff <= {pbpe_pkg::store_byte(rd_b), pbpe_pkg::store_byte(rd_a), byte01_ff};
         end
         pbpe_pkg::CMD_MUL: begin
            prod_ff <= PW'(mag_a) * PW'(mag_b);
            neg_ff  <= rd_a[VB-1] ^ rd_b[VB-1];
         end
         pbpe_pkg::CMD_RND: begin
            q_ff <= neg_ff ? -$signed({1'b0, rnd_sum[PW:FB]})
                           :  $signed({1'b0, rnd_sum[PW:FB]});
         end
         pbpe_pkg::CMD_RESULT: begin
            out_rgba_ff  <= pix_ff;
            out_fault_ff <= fault_ff;
            out_last_ff  <= last_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tdata = out_rgba_ff;
   assign rsp_tuser = out_fault_ff;
   assign rsp_tlast = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_blend_program_engine.sv =====
// Top level of the pixel blend program engine: sequencer plus datapath.
// Depends on pbpe_pkg, pbpe_ctrl and pbpe_dpath.
`default_nettype none

// Channel  | Signals                               | Direction | Beat content
// ---------+---------------------------------------+-----------+-------------------------------
// request  | req_tvalid/tready/tdata/tuser/tlast   | in        | program word or one pixel
// response | rsp_tvalid/tready/tdata/tuser/tlast   | out       | final pixel, fault, last flag
// config   | csr_wr_en/csr_wr_data                 | in        | program_length
//
// A program-word beat is stored on acceptance. A pixel beat runs the stored program, one
// instruction after the other, through a shared register file with two read ports and one
// write port: splat, ldcov and faulting or unknown instructions end at decode, others after
// their writeback, store, load or multiply steps, and a final step delivers the result.
// Reset is synchronous and clears the sequencer, the program length and the fault flag; the
// program store holds no reset value. The request side is stalled while a pixel runs and
// while its result waits behind an earlier result that was not yet taken.

module pixel_blend_program_engine #(
   parameter int PROG_DEPTH = pbpe_pkg::PROG_DEPTH_DEF,
   parameter int REG_COUNT  = pbpe_pkg::REG_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // prog_addr, op_kind, reg_d, reg_a, reg_b, reg_c, imm, src_rgba, dst_rgba, coverage, pad
   input  wire logic [pbpe_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_rgba
   output      logic [31:0]                        rsp_tdata,
   // index_fault
   output      logic                               rsp_tuser,
   output      logic                               rsp_tlast,
   input  wire logic                               csr_wr_en,
   input  wire logic [4:0]                         csr_wr_data
);

   pbpe_pkg::cmd_type                   cmd;
   pbpe_pkg::status_type                status;
   // The program counter lives in the sequencer; the datapath sees it as its fetch address.
   logic [$clog2(PROG_DEPTH+1)-1:0]     pc;

   pbpe_ctrl #(
      .PROG_DEPTH (PROG_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tuser   (req_tuser),
      .req_tready  (req_tready),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pc          (pc),
      .cmd         (cmd),
      .status      (status)
   );

   pbpe_dpath #(
      .PROG_DEPTH (PROG_DEPTH),
      .REG_COUNT  (REG_COUNT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .pc        (pc),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // A pixel beat always keeps the request side stalled in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !req_tready)
      else $error("request accepted again right after a pixel beat");

   // A new result only appears at the end of a pixel, never while requests are open.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised without a pixel in flight");

endmodule

`default_nettype wire
